/* rtl/core/radius_query_point_table_unit_defines.svh */
// Assertion macros shared by the point table RTL.
`ifndef RADIUS_QUERY_POINT_TABLE_UNIT_DEFINES_SVH
`define RADIUS_QUERY_POINT_TABLE_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RQPT_ASSERT_IMP(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define RQPT_ASSERT_NXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

/* rtl/core/rqpt_pkg.sv */
// Shared constants, codes and types of the point table.
package rqpt_pkg;

   localparam int CAPACITY   = 32;
   localparam int KEY_BITS   = 32;
   localparam int COORD_BITS = 16;

   localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_BITS   = $clog2(CAPACITY + 1);
   localparam int RAD_BITS   = COORD_BITS + 1;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int SQ_BITS    = 2 * DIFF_BITS;
   localparam int ENTRY_BITS = KEY_BITS + 2 * COORD_BITS;

   typedef logic [IDX_BITS-1:0]          idx_type;
   typedef logic [CNT_BITS-1:0]          count_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic [1:0]                   status_type;
   typedef logic [2:0]                   op_type;

   localparam count_type CAP_COUNT = count_type'(CAPACITY);

   localparam op_type OP_INSERT = 3'd0;
   localparam op_type OP_UPDATE = 3'd1;
   localparam op_type OP_REMOVE = 3'd2;
   localparam op_type OP_CLEAR  = 3'd3;
   localparam op_type OP_QUERY  = 3'd4;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_FOUND = 2'd1;
   localparam status_type STATUS_FULL      = 2'd2;
   localparam status_type STATUS_NO_MATCH  = 2'd3;

   typedef struct packed {
      logic [KEY_BITS-1:0]          key;
      logic signed [COORD_BITS-1:0] x;
      logic signed [COORD_BITS-1:0] y;
   } entry_type;

   // An entry read from the table on its way into the match pipeline.
   typedef struct packed {
      logic    valid;
      idx_type idx;
   } stage_type;

   // Outcome for one entry at the end of the match pipeline.
   typedef struct packed {
      logic                valid;
      logic                busy;
      idx_type             idx;
      logic [KEY_BITS-1:0] key;
      logic                key_hit;
      logic                in_range;
   } dec_type;

endpackage

/* rtl/core/rqpt_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
module rqpt_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 32,
   localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   // The read data holds while no read is issued, so a stalled scan keeps its entry.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/rqpt_match.sv */
// Match pipeline: key compare and squared distance test for one entry per cycle while adv is high.
module rqpt_match (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 adv,
   input  logic                                 flush,
   input  rqpt_pkg::stage_type                  s1,
   input  rqpt_pkg::entry_type                  entry,
   input  logic [rqpt_pkg::KEY_BITS-1:0]        qry_key,
   input  logic signed [rqpt_pkg::COORD_BITS-1:0] qry_x,
   input  logic signed [rqpt_pkg::COORD_BITS-1:0] qry_y,
   input  logic [rqpt_pkg::SQ_BITS-1:0]         r2,
   output rqpt_pkg::dec_type                    dec
);

   logic                                v2_ff;
   logic                                v3_ff;
   rqpt_pkg::idx_type                   idx2_ff;
   rqpt_pkg::idx_type                   idx3_ff;
   logic [rqpt_pkg::KEY_BITS-1:0]       key2_ff;
   logic [rqpt_pkg::KEY_BITS-1:0]       key3_ff;
   logic                                hit2_ff;
   logic                                hit3_ff;
   rqpt_pkg::diff_type                  dx_ff;
   rqpt_pkg::diff_type                  dy_ff;
   logic [rqpt_pkg::SQ_BITS-1:0]        sqx_ff;
   logic [rqpt_pkg::SQ_BITS-1:0]        sqy_ff;
   logic signed [rqpt_pkg::SQ_BITS-1:0] prod_x;
   logic signed [rqpt_pkg::SQ_BITS-1:0] prod_y;
   logic [rqpt_pkg::SQ_BITS:0]          dist_sum;

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v2_ff <= s1.valid;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         idx2_ff <= s1.idx;
         key2_ff <= entry.key;
         hit2_ff <= (entry.key == qry_key);
         dx_ff   <= rqpt_pkg::diff_type'(entry.x) - rqpt_pkg::diff_type'(qry_x);
         dy_ff   <= rqpt_pkg::diff_type'(entry.y) - rqpt_pkg::diff_type'(qry_y);
         idx3_ff <= idx2_ff;
         key3_ff <= key2_ff;
         hit3_ff <= hit2_ff;
         sqx_ff  <= prod_x;
         sqy_ff  <= prod_y;
      end
   end

   assign prod_x   = dx_ff * dx_ff;
   assign prod_y   = dy_ff * dy_ff;
   assign dist_sum = {1'b0, sqx_ff} + {1'b0, sqy_ff};

   always_comb begin
      dec.valid    = v3_ff;
      dec.busy     = v2_ff || v3_ff;
      dec.idx      = idx3_ff;
      dec.key      = key3_ff;
      dec.key_hit  = hit3_ff;
      dec.in_range = (dist_sum <= {1'b0, r2});
   end

endmodule

/* rtl/core/radius_query_point_table_unit.sv */
// Ordered point table with insert, update, remove, clear and radius query.
//
//  channel | dir | handshake           | payload
//  req     | in  | req_valid/req_stall | req_op, req_key, req_pos_x, req_pos_y, req_radius
//  rsp     | out | rsp_valid/rsp_stall | rsp_found_key, rsp_status, rsp_last
//
// Insert and clear go straight to the done state; no new request is taken until the response is pushed.
// A scan reads one entry a cycle through the single RAM read port while no held query match
// stalls it; an update that finds its key writes it back, and a removal that finds it shifts
// the later entries down in the shift state before it responds.
// Reset clears the entry count; the table contents are left as they are.
// While the output register is stalled, a query holding a second match pauses its scan.
module radius_query_point_table_unit (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  rqpt_pkg::op_type                       req_op,
   input  logic [rqpt_pkg::KEY_BITS-1:0]          req_key,
   input  logic signed [rqpt_pkg::COORD_BITS-1:0] req_pos_x,
   input  logic signed [rqpt_pkg::COORD_BITS-1:0] req_pos_y,
   input  logic [rqpt_pkg::RAD_BITS-1:0]          req_radius,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [rqpt_pkg::KEY_BITS-1:0]          rsp_found_key,
   output rqpt_pkg::status_type                   rsp_status,
   output logic                                   rsp_last
);

`include "radius_query_point_table_unit_defines.svh"

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_SHIFT = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type                             state_ff, state_in;
   rqpt_pkg::op_type                      op_ff;
   logic [rqpt_pkg::KEY_BITS-1:0]         key_ff;
   logic signed [rqpt_pkg::COORD_BITS-1:0] px_ff;
   logic signed [rqpt_pkg::COORD_BITS-1:0] py_ff;
   logic [rqpt_pkg::RAD_BITS-1:0]         rad_ff;
   logic [rqpt_pkg::SQ_BITS-1:0]          r2_ff;
   rqpt_pkg::count_type                   count_ff, count_in;
   rqpt_pkg::count_type                   issue_ff, issue_in;
   rqpt_pkg::stage_type                   s1_ff, s1_in;
   logic                                  pend_valid_ff, pend_valid_in;
   logic [rqpt_pkg::KEY_BITS-1:0]         pend_key_ff, pend_key_in;
   logic [rqpt_pkg::KEY_BITS-1:0]         fin_key_ff, fin_key_in;
   rqpt_pkg::status_type                  fin_status_ff, fin_status_in;
   logic                                  rsp_valid_ff;
   logic [rqpt_pkg::KEY_BITS-1:0]         rsp_key_ff;
   rqpt_pkg::status_type                  rsp_status_ff;
   logic                                  rsp_last_ff;

   logic                                  accept;
   logic                                  accept_query;
   logic                                  out_free;
   logic                                  push;
   logic [rqpt_pkg::KEY_BITS-1:0]         push_key;
   rqpt_pkg::status_type                  push_status;
   logic                                  push_last;
   logic                                  adv;
   logic                                  flush;
   logic                                  issue;
   logic                                  wr_en;
   rqpt_pkg::idx_type                     wr_addr;
   rqpt_pkg::entry_type                   wr_data;
   rqpt_pkg::entry_type                   rd_entry;
   rqpt_pkg::stage_type                   s1_scan;
   rqpt_pkg::dec_type                     dec;

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign accept_query = accept && (req_op == rqpt_pkg::OP_QUERY);
   assign out_free     = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      issue_in      = issue_ff;
      s1_in         = s1_ff;
      pend_valid_in = pend_valid_ff;
      pend_key_in   = pend_key_ff;
      fin_key_in    = fin_key_ff;
      fin_status_in = fin_status_ff;
      push          = 1'b0;
      push_key      = '0;
      push_status   = rqpt_pkg::STATUS_OK;
      push_last     = 1'b0;
      adv           = 1'b1;
      flush         = 1'b0;
      issue         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fin_key_in    = '0;
               fin_status_in = rqpt_pkg::STATUS_OK;
               issue_in      = '0;
               pend_valid_in = 1'b0;
               case (req_op)
                  rqpt_pkg::OP_INSERT: begin
                     if (count_ff < rqpt_pkg::CAP_COUNT) begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[rqpt_pkg::IDX_BITS-1:0];
                        wr_data  = {req_key, req_pos_x, req_pos_y};
                        count_in = count_ff + 1'b1;
                     end else begin
                        fin_status_in = rqpt_pkg::STATUS_FULL;
                     end
                     state_in = ST_DONE;
                  end
                  rqpt_pkg::OP_UPDATE, rqpt_pkg::OP_REMOVE, rqpt_pkg::OP_QUERY: begin
                     state_in = ST_SCAN;
                  end
                  rqpt_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = ST_DONE;
                  end
                  default: begin
                     // Unused operation codes are dropped without a response.
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (dec.valid && (op_ff != rqpt_pkg::OP_QUERY) && dec.key_hit) begin
               // First matching key: drop the entries still in flight behind it.
               flush          = 1'b1;
               s1_in.valid    = 1'b0;
               if (op_ff == rqpt_pkg::OP_UPDATE) begin
                  wr_en    = 1'b1;
                  wr_addr  = dec.idx;
                  wr_data  = {key_ff, px_ff, py_ff};
                  state_in = ST_DONE;
               end else begin
                  issue_in = rqpt_pkg::count_type'(dec.idx) + 1'b1;
                  state_in = ST_SHIFT;
               end
            end else begin
               // One match is always held back so that the final one can carry last.
               if (dec.valid && (op_ff == rqpt_pkg::OP_QUERY) && dec.in_range) begin
                  if (!pend_valid_ff) begin
                     pend_valid_in = 1'b1;
                     pend_key_in   = dec.key;
                  end else if (out_free) begin
                     push        = 1'b1;
                     push_key    = pend_key_ff;
                     push_status = rqpt_pkg::STATUS_OK;
                     push_last   = 1'b0;
                     pend_key_in = dec.key;
                  end else begin
                     adv = 1'b0;
                  end
               end
               if (adv) begin
                  issue       = (issue_ff < count_ff);
                  s1_in.valid = issue;
                  s1_in.idx   = issue_ff[rqpt_pkg::IDX_BITS-1:0];
                  if (issue) begin
                     issue_in = issue_ff + 1'b1;
                  end
               end
               if (!issue && !s1_ff.valid && !dec.busy) begin
                  if (op_ff == rqpt_pkg::OP_QUERY) begin
                     fin_key_in    = pend_valid_ff ? pend_key_ff : '0;
                     fin_status_in = pend_valid_ff ? rqpt_pkg::STATUS_OK
                                                   : rqpt_pkg::STATUS_NO_MATCH;
                     pend_valid_in = 1'b0;
                  end else begin
                     fin_status_in = rqpt_pkg::STATUS_NOT_FOUND;
                  end
                  state_in = ST_DONE;
               end
            end
         end

         ST_SHIFT: begin
            // Read entry i while entry i - 2 receives entry i - 1, read the cycle before.
            issue       = (issue_ff < count_ff);
            s1_in.valid = issue;
            s1_in.idx   = issue_ff[rqpt_pkg::IDX_BITS-1:0];
            if (issue) begin
               issue_in = issue_ff + 1'b1;
            end
            if (s1_ff.valid) begin
               wr_en   = 1'b1;
               wr_addr = s1_ff.idx - 1'b1;
               wr_data = rd_entry;
            end
            if (!issue && !s1_ff.valid) begin
               count_in = count_ff - 1'b1;
               state_in = ST_DONE;
            end
         end

         ST_DONE: begin
            if (out_free) begin
               push        = 1'b1;
               push_key    = fin_key_ff;
               push_status = fin_status_ff;
               push_last   = 1'b1;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         issue_ff      <= '0;
         s1_ff         <= '0;
         pend_valid_ff <= 1'b0;
         fin_status_ff <= rqpt_pkg::STATUS_OK;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         issue_ff      <= issue_in;
         s1_ff         <= s1_in;
         pend_valid_ff <= pend_valid_in;
         fin_status_ff <= fin_status_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff  <= req_op;
         key_ff <= req_key;
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         rad_ff <= req_radius;
      end
      r2_ff       <= rqpt_pkg::SQ_BITS'(rad_ff) * rqpt_pkg::SQ_BITS'(rad_ff);
      pend_key_ff <= pend_key_in;
      fin_key_ff  <= fin_key_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (push) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_key_ff    <= push_key;
         rsp_status_ff <= push_status;
         rsp_last_ff   <= push_last;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_found_key = rsp_key_ff;
   assign rsp_status    = rsp_status_ff;
   assign rsp_last      = rsp_last_ff;

   assign s1_scan.valid = s1_ff.valid && (state_ff == ST_SCAN);
   assign s1_scan.idx   = s1_ff.idx;

   rqpt_ram #(
      .WIDTH (rqpt_pkg::ENTRY_BITS),
      .DEPTH (rqpt_pkg::CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (issue_ff[rqpt_pkg::IDX_BITS-1:0]),
      .rd_data (rd_entry)
   );

   rqpt_match u_match (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .flush   (flush),
      .s1      (s1_scan),
      .entry   (rd_entry),
      .qry_key (key_ff),
      .qry_x   (px_ff),
      .qry_y   (py_ff),
      .r2      (r2_ff),
      .dec     (dec)
   );

   `RQPT_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= rqpt_pkg::CAP_COUNT, "count above capacity")
   `RQPT_ASSERT_IMP(a_push_free, push, out_free, "response overwritten while stalled")
   `RQPT_ASSERT_IMP(a_pend_scan, pend_valid_ff, state_ff == ST_SCAN, "held match outside a scan")
   `RQPT_ASSERT_NXT(a_query_start, accept_query, state_ff == ST_SCAN, "query did not start a scan")
   `RQPT_ASSERT_IMP(a_shift_count, state_ff == ST_SHIFT, count_ff != '0, "shift on an empty table")

endmodule
